>>> src/assert_macros.svh
// Assertion macros for the RTL, included by the controller (nrmc_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Same check, written for a plain always-true condition.
`define ASSERT_ALWAYS(label, cond, msg) \
	`ASSERT_CLK(label, 1'b1 |-> (cond), msg)
`endif

>>> src/nrmc_pkg.sv
// Package: characters, field codes, tables and control types of the RMC parser.
package nrmc_pkg;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_E      = 8'h45;

	localparam logic [3:0] FLD_HDR  = 4'd0;
	localparam logic [3:0] FLD_TIME = 4'd1;
	localparam logic [3:0] FLD_LAT  = 4'd3;
	localparam logic [3:0] FLD_NS   = 4'd4;
	localparam logic [3:0] FLD_LON  = 4'd5;
	localparam logic [3:0] FLD_EW   = 4'd6;
	localparam logic [3:0] FLD_DATE = 4'd9;

	localparam logic [29:0] LAT_MAX_UNITS = 30'd540000000;
	localparam logic [30:0] LON_MAX_UNITS = 31'd1080000000;

	typedef struct packed {
		logic capture;
		logic units;
		logic step;
		logic e1;
		logic e2;
		logic e3;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic emit;
	} sts_t;

	function automatic logic [13:0] frac_weight(input logic [3:0] idx);
		case (idx)
			4'd0: frac_weight = 14'd10000;
			4'd1: frac_weight = 14'd1000;
			4'd2: frac_weight = 14'd100;
			4'd3: frac_weight = 14'd10;
			4'd4: frac_weight = 14'd1;
			default: frac_weight = 14'd0;
		endcase
	endfunction

	// (153*mp+2)/5 with mp the March-based month
	function automatic logic [8:0] doy_base(input logic [3:0] m);
		case (m)
			4'd1: doy_base = 9'd306;
			4'd2: doy_base = 9'd337;
			4'd3: doy_base = 9'd0;
			4'd4: doy_base = 9'd31;
			4'd5: doy_base = 9'd61;
			4'd6: doy_base = 9'd92;
			4'd7: doy_base = 9'd122;
			4'd8: doy_base = 9'd153;
			4'd9: doy_base = 9'd184;
			4'd10: doy_base = 9'd214;
			4'd11: doy_base = 9'd245;
			4'd12: doy_base = 9'd275;
			default: doy_base = 9'd0;
		endcase
	endfunction
endpackage

>>> src/nrmc_ctrl.sv
// Controller: sequences capture, coordinate scaling, character step, date arithmetic and output load.
`include "assert_macros.svh"
module nrmc_ctrl
	import nrmc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_UNITS, S_STEP, S_E1, S_E2, S_E3, S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.capture = in_valid && (state_q == S_IDLE);
		cmd.units   = (state_q == S_UNITS);
		cmd.step    = (state_q == S_STEP);
		cmd.e1      = (state_q == S_E1);
		cmd.e2      = (state_q == S_E2);
		cmd.e3      = (state_q == S_E3);
		cmd.load    = (state_q == S_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_UNITS;
				S_UNITS: state_q <= S_STEP;
				S_STEP:  state_q <= sts.emit ? S_E1 : S_FIN;
				S_E1:    state_q <= S_E2;
				S_E2:    state_q <= S_E3;
				S_E3:    state_q <= S_FIN;
				S_FIN:   if (!out_valid_q || out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_accept_busy, in_valid && in_ready |=> !in_ready, "input taken while busy")
	`ASSERT_CLK(a_date_seq, cmd.e1 |=> cmd.e2 ##1 cmd.e3, "date arithmetic out of order")
	`ASSERT_CLK(a_load_free, cmd.load |-> (!out_valid || out_ready), "result overwritten")
endmodule

>>> src/nrmc_dp.sv
// Datapath: field accumulators, range checks, date arithmetic and result registers.
module nrmc_dp
	import nrmc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [7:0]         rx_char,
	input  logic               pps,
	output logic               valid_res,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second,
	output logic [4:0]         day,
	output logic [3:0]         month,
	output logic [11:0]        year,
	output logic [16:0]        sec_of_day,
	output logic signed [30:0] latitude,
	output logic signed [31:0] longitude,
	output logic [31:0]        utc_seconds
);
	logic [7:0]  c_q;
	logic        pps_q;
	logic        in_sent_q, hg_q, de_q, emit_q;
	logic [3:0]  fi_q, pos_q;
	logic [4:0]  hour_q, day_q;
	logic [5:0]  min_q, sec_q, lat_min_q, lon_min_q;
	logic [3:0]  month_q;
	logic [6:0]  year_q, lat_deg_q;
	logic [7:0]  lon_deg_q;
	logic [16:0] lat_frac_q, lon_frac_q;
	logic        south_q, west_q;
	logic [29:0] lat_units_q;
	logic [30:0] lon_units_q;
	logic [16:0] sod_s1;
	logic [9:0]  yoe_s1;
	logic [8:0]  doy_s1;
	logic [17:0] days_s2;
	logic [31:0] utc_s3;

	logic        in_sent_n, hg_n, de_n, emit_n;
	logic [3:0]  fi_n, pos_n;
	logic [4:0]  hour_n, day_n;
	logic [5:0]  min_n, sec_n, lat_min_n, lon_min_n;
	logic [3:0]  month_n;
	logic [6:0]  year_n, lat_deg_n;
	logic [7:0]  lon_deg_n;
	logic [16:0] lat_frac_n, lon_frac_n;
	logic        south_n, west_n;

	logic        valid_q, south_o_q, west_o_q;
	logic [4:0]  hour_o_q, day_o_q;
	logic [5:0]  min_o_q, sec_o_q;
	logic [3:0]  month_o_q;
	logic [11:0] year_o_q;
	logic [16:0] sod_o_q;
	logic [30:0] lat_o_q;
	logic [31:0] lon_o_q, utc_o_q;

	function automatic logic [9:0] mul10add(input logic [7:0] t, input logic [3:0] dg);
		mul10add = 10'(t) * 10'd10 + 10'(dg);
	endfunction

	assign sts.emit = emit_n;

	always_comb begin
		logic       isd, want, term;
		logic [3:0] d;
		logic [9:0] v;
		in_sent_n = in_sent_q; hg_n = hg_q; de_n = de_q; emit_n = 1'b0;
		fi_n = fi_q; pos_n = pos_q;
		hour_n = hour_q; min_n = min_q; sec_n = sec_q;
		day_n = day_q; month_n = month_q; year_n = year_q;
		lat_deg_n = lat_deg_q; lat_min_n = lat_min_q; lat_frac_n = lat_frac_q;
		lon_deg_n = lon_deg_q; lon_min_n = lon_min_q; lon_frac_n = lon_frac_q;
		south_n = south_q; west_n = west_q;
		isd  = (c_q >= CH_0) && (c_q <= CH_9);
		d    = isd ? 4'(c_q - CH_0) : 4'd0;
		want = 1'b0;
		v    = '0;
		term = (c_q == CH_COMMA) || (c_q == CH_STAR) || (c_q == CH_CR) || (c_q == CH_LF);
		if (c_q == CH_DOLLAR) begin
			in_sent_n = pps_q; hg_n = pps_q; de_n = 1'b0;
			fi_n = '0; pos_n = '0;
			hour_n = '0; min_n = '0; sec_n = '0;
			day_n = '0; month_n = '0; year_n = '0;
			lat_deg_n = '0; lat_min_n = '0; lat_frac_n = '0;
			lon_deg_n = '0; lon_min_n = '0; lon_frac_n = '0;
			south_n = pps_q; west_n = pps_q;
		end else if (in_sent_q) begin
			if (term) begin
				case (fi_q)
					FLD_HDR:  if (pos_q != 4'd5) hg_n = 1'b0;
					FLD_TIME: if (pos_q < 4'd6) de_n = 1'b1;
					FLD_LAT:  if (pos_q < 4'd4 || lat_units_q > LAT_MAX_UNITS) de_n = 1'b1;
					FLD_LON:  if (pos_q < 4'd5 || lon_units_q > LON_MAX_UNITS) de_n = 1'b1;
					FLD_DATE: if (pos_q != 4'd6) de_n = 1'b1;
					default: ;
				endcase
				if (c_q == CH_COMMA) begin
					if (fi_q != 4'd15) fi_n = fi_q + 4'd1;
					pos_n = '0;
				end else begin
					emit_n    = hg_n && !de_n && (fi_q >= FLD_DATE);
					in_sent_n = 1'b0;
				end
			end else begin
				case (fi_q)
					FLD_HDR: if ((pos_q == 4'd2 && c_q != CH_R) ||
							(pos_q == 4'd3 && c_q != CH_M) ||
							(pos_q == 4'd4 && c_q != CH_C)) hg_n = 1'b0;
					FLD_TIME: if (pos_q == 4'd6) begin
						if (c_q != CH_DOT) de_n = 1'b1;
					end else begin
						want = 1'b1;
						case (pos_q)
							4'd0: hour_n = 5'(d);
							4'd1: begin
								v = mul10add(8'(hour_q), d);
								if (v > 10'd23) de_n = 1'b1;
								hour_n = v[4:0];
							end
							4'd2: min_n = 6'(d);
							4'd3: begin
								v = mul10add(8'(min_q), d);
								if (v > 10'd59) de_n = 1'b1;
								min_n = v[5:0];
							end
							4'd4: sec_n = 6'(d);
							4'd5: begin
								v = mul10add(8'(sec_q), d);
								if (v > 10'd60) de_n = 1'b1;
								sec_n = v[5:0];
							end
							default: ;
						endcase
					end
					FLD_LAT: if (pos_q == 4'd4) begin
						if (c_q != CH_DOT) de_n = 1'b1;
					end else begin
						want = 1'b1;
						case (pos_q)
							4'd0: lat_deg_n = 7'(d);
							4'd1: begin
								v = mul10add(8'(lat_deg_q), d);
								if (v > 10'd90) de_n = 1'b1;
								lat_deg_n = v[6:0];
							end
							4'd2: lat_min_n = 6'(d);
							4'd3: begin
								v = mul10add(8'(lat_min_q), d);
								if (v > 10'd59) de_n = 1'b1;
								lat_min_n = v[5:0];
							end
							4'd5, 4'd6, 4'd7, 4'd8, 4'd9:
								lat_frac_n = lat_frac_q +
									17'(18'(d) * 18'(frac_weight(4'(pos_q - 4'd5))));
							default: ;
						endcase
					end
					FLD_NS: if (pos_q == 4'd0) south_n = (c_q != CH_N);
					FLD_LON: if (pos_q == 4'd5) begin
						if (c_q != CH_DOT) de_n = 1'b1;
					end else begin
						want = 1'b1;
						case (pos_q)
							4'd0: lon_deg_n = 8'(d);
							4'd1: begin
								v = mul10add(lon_deg_q, d);
								lon_deg_n = v[7:0];
							end
							4'd2: begin
								v = mul10add(lon_deg_q, d);
								if (v > 10'd180) de_n = 1'b1;
								lon_deg_n = v[7:0];
							end
							4'd3: lon_min_n = 6'(d);
							4'd4: begin
								v = mul10add(8'(lon_min_q), d);
								if (v > 10'd59) de_n = 1'b1;
								lon_min_n = v[5:0];
							end
							4'd6, 4'd7, 4'd8, 4'd9, 4'd10:
								lon_frac_n = lon_frac_q +
									17'(18'(d) * 18'(frac_weight(4'(pos_q - 4'd6))));
							default: ;
						endcase
					end
					FLD_EW: if (pos_q == 4'd0) west_n = (c_q != CH_E);
					FLD_DATE: begin
						want = 1'b1;
						case (pos_q)
							4'd0: day_n = 5'(d);
							4'd1: begin
								v = mul10add(8'(day_q), d);
								if (v < 10'd1 || v > 10'd31) de_n = 1'b1;
								day_n = v[4:0];
							end
							4'd2: month_n = d;
							4'd3: begin
								v = mul10add(8'(month_q), d);
								if (v < 10'd1 || v > 10'd12) de_n = 1'b1;
								month_n = v[3:0];
							end
							4'd4: year_n = 7'(d);
							4'd5: begin
								v = mul10add(8'(year_q), d);
								if (v > 10'd99) de_n = 1'b1;
								year_n = v[6:0];
							end
							default: ;
						endcase
					end
					default: ;
				endcase
				if (want && !isd) de_n = 1'b1;
				if (pos_q != 4'd15) pos_n = pos_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q <= 1'b0; hg_q <= 1'b0; de_q <= 1'b0; emit_q <= 1'b0;
			fi_q <= '0; pos_q <= '0;
			hour_q <= '0; min_q <= '0; sec_q <= '0;
			day_q <= '0; month_q <= '0; year_q <= '0;
			lat_deg_q <= '0; lat_min_q <= '0; lat_frac_q <= '0; south_q <= 1'b0;
			lon_deg_q <= '0; lon_min_q <= '0; lon_frac_q <= '0; west_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				in_sent_q <= in_sent_n; hg_q <= hg_n; de_q <= de_n; emit_q <= emit_n;
				fi_q <= fi_n; pos_q <= pos_n;
				hour_q <= hour_n; min_q <= min_n; sec_q <= sec_n;
				day_q <= day_n; month_q <= month_n; year_q <= year_n;
				lat_deg_q <= lat_deg_n; lat_min_q <= lat_min_n; lat_frac_q <= lat_frac_n;
				south_q <= south_n;
				lon_deg_q <= lon_deg_n; lon_min_q <= lon_min_n; lon_frac_q <= lon_frac_n;
				west_q <= west_n;
			end
			if (cmd.load) valid_q <= emit_q;
		end
	end

	// yoe_s1 counts years from 1600; over 1999..2099 the century and
	// 400-year leap corrections together always remove 3 days
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			c_q   <= rx_char;
			pps_q <= pps;
		end
		if (cmd.units) begin
			lat_units_q <= 30'(13'(lat_deg_q) * 13'd60 + 13'(lat_min_q)) * 30'd100000
				+ 30'(lat_frac_q);
			lon_units_q <= 31'(14'(lon_deg_q) * 14'd60 + 14'(lon_min_q)) * 31'd100000
				+ 31'(lon_frac_q);
		end
		if (cmd.e1) begin
			sod_s1 <= 17'(hour_q) * 17'd3600 + 17'(min_q) * 17'd60 + 17'(sec_q);
			yoe_s1 <= 10'd400 + 10'(year_q) - ((month_q <= 4'd2) ? 10'd1 : 10'd0);
			doy_s1 <= doy_base(month_q) + 9'(day_q) - 9'd1;
		end
		if (cmd.e2) begin
			days_s2 <= 18'(yoe_s1) * 18'd365 + 18'(yoe_s1[9:2]) - 18'd3
				+ 18'(doy_s1) - 18'd135080;
		end
		if (cmd.e3) utc_s3 <= 32'(days_s2) * 32'd86400 + 32'(sod_s1);
		if (cmd.load) begin
			hour_o_q  <= emit_q ? hour_q : '0;
			min_o_q   <= emit_q ? min_q : '0;
			sec_o_q   <= emit_q ? sec_q : '0;
			day_o_q   <= emit_q ? day_q : '0;
			month_o_q <= emit_q ? month_q : '0;
			year_o_q  <= emit_q ? 12'd2000 + 12'(year_q) : '0;
			sod_o_q   <= emit_q ? sod_s1 : '0;
			south_o_q <= south_q;
			west_o_q  <= west_q;
			lat_o_q   <= emit_q ? 31'(lat_units_q) : '0;
			lon_o_q   <= emit_q ? 32'(lon_units_q) : '0;
			utc_o_q   <= emit_q ? utc_s3 : '0;
		end
	end

	assign valid_res   = valid_q;
	assign hour        = hour_o_q;
	assign minute      = min_o_q;
	assign second      = sec_o_q;
	assign day         = day_o_q;
	assign month       = month_o_q;
	assign year        = year_o_q;
	assign sec_of_day  = sod_o_q;
	assign latitude    = $signed(south_o_q ? 31'd0 - lat_o_q : lat_o_q);
	assign longitude   = $signed(west_o_q ? 32'd0 - lon_o_q : lon_o_q);
	assign utc_seconds = utc_o_q;
endmodule

>>> src/nmea_rmc_time_position_parser.sv
// Top level of the NMEA RMC time and position parser.
// Input channel: one received character (rx_char) and the PPS level per item,
// on in_valid/in_ready. Output channel: one result item per input item on
// out_valid/out_ready; valid_res is 1 only for the terminator of a good RMC
// sentence, and every other field is then zero when valid_res is 0.
// Sequence: after its character is accepted, a result goes through coordinate
// scaling, character step and output load; a terminator that closes a good
// sentence also passes the date and epoch arithmetic steps (E1, E2, E3) before
// the load. The controller takes no new item until the result of the last one
// is loaded, as set by its per-character sequence.
// Reset: asynchronous, active low; clears the sentence state and output valid.
// Stall: a finished result holds in the output register until taken; the
// controller waits in its final step and takes no new item meanwhile.
module nmea_rmc_time_position_parser
	import nrmc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_char,
	input  logic               pps,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               valid_res,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second,
	output logic [4:0]         day,
	output logic [3:0]         month,
	output logic [11:0]        year,
	output logic [16:0]        sec_of_day,
	output logic signed [30:0] latitude,
	output logic signed [31:0] longitude,
	output logic [31:0]        utc_seconds
);
	cmd_t cmd;
	sts_t sts;

	nrmc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	nrmc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.rx_char(rx_char), .pps(pps),
		.valid_res(valid_res), .hour(hour), .minute(minute), .second(second),
		.day(day), .month(month), .year(year), .sec_of_day(sec_of_day),
		.latitude(latitude), .longitude(longitude), .utc_seconds(utc_seconds)
	);
endmodule

>>> tb/nrmc_checker.sv
// Checker for the RMC parser: predicts each result item and compares it on the output channel.
`timescale 1ns / 1ps
module nrmc_checker
	import nrmc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         rx_char,
	input  logic               pps,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               valid_res,
	input  logic [4:0]         hour,
	input  logic [5:0]         minute,
	input  logic [5:0]         second,
	input  logic [4:0]         day,
	input  logic [3:0]         month,
	input  logic [11:0]        year,
	input  logic [16:0]        sec_of_day,
	input  logic signed [30:0] latitude,
	input  logic signed [31:0] longitude,
	input  logic [31:0]        utc_seconds,
	output int                 errors,
	output int                 pending
);
	typedef struct packed {
		logic        valid_res;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		logic [16:0] sec_of_day;
		logic [30:0] latitude;
		logic [31:0] longitude;
		logic [31:0] utc_seconds;
	} fix_t;

	fix_t fix_q[$];

	logic        open_s, hdr_ok, bad;
	logic [3:0]  fld, cpos;
	logic [4:0]  hh, dd;
	logic [5:0]  mm, ss;
	logic [3:0]  mo;
	logic [6:0]  yy;
	logic [6:0]  lat_d;
	logic [5:0]  lat_m;
	logic [16:0] lat_f;
	logic        south;
	logic [7:0]  lon_d;
	logic [5:0]  lon_m;
	logic [16:0] lon_f;
	logic        west;

	task automatic clear_sentence();
		open_s = 0; hdr_ok = 0; fld = 0; cpos = 0; bad = 0;
		hh = 0; mm = 0; ss = 0; dd = 0; mo = 0; yy = 0;
		lat_d = 0; lat_m = 0; lat_f = 0; south = 0;
		lon_d = 0; lon_m = 0; lon_f = 0; west = 0;
	endtask

	function automatic int unsigned pair(int unsigned tens, int unsigned d,
			int unsigned lo, int unsigned hi);
		int unsigned v;
		v = tens * 10 + d;
		if (v < lo || v > hi)
			bad = 1;
		return v;
	endfunction

	function automatic int unsigned pow10(int unsigned k);
		int unsigned w;
		w = 1;
		repeat (4 - k) w = w * 10;
		return w;
	endfunction

	function automatic logic [31:0] lat_units();
		return (32'(lat_d) * 60 + 32'(lat_m)) * 100000 + 32'(lat_f);
	endfunction

	function automatic logic [31:0] lon_units();
		return (32'(lon_d) * 60 + 32'(lon_m)) * 100000 + 32'(lon_f);
	endfunction

	task automatic take_char(input logic [7:0] c);
		logic isd, want;
		int unsigned d;
		isd = (c >= CH_0 && c <= CH_9);
		d = isd ? 32'(c - CH_0) : 0;
		want = 0;
		case (fld)
			FLD_HDR: begin
				if ((cpos == 2 && c != CH_R) || (cpos == 3 && c != CH_M) ||
						(cpos == 4 && c != CH_C))
					hdr_ok = 0;
			end
			FLD_TIME: begin
				if (cpos == 6) begin
					if (c != CH_DOT) bad = 1;
				end else begin
					want = 1;
					case (cpos)
						0: hh = 5'(d);
						1: hh = 5'(pair(32'(hh), d, 0, 23));
						2: mm = 6'(d);
						3: mm = 6'(pair(32'(mm), d, 0, 59));
						4: ss = 6'(d);
						5: ss = 6'(pair(32'(ss), d, 0, 60));
						default: ;
					endcase
				end
			end
			FLD_LAT: begin
				if (cpos == 4) begin
					if (c != CH_DOT) bad = 1;
				end else begin
					want = 1;
					if (cpos == 0) lat_d = 7'(d);
					else if (cpos == 1) lat_d = 7'(pair(32'(lat_d), d, 0, 90));
					else if (cpos == 2) lat_m = 6'(d);
					else if (cpos == 3) lat_m = 6'(pair(32'(lat_m), d, 0, 59));
					else if (cpos >= 5 && cpos <= 9)
						lat_f = 17'(32'(lat_f) + d * pow10(32'(cpos) - 5));
				end
			end
			FLD_NS: if (cpos == 0) south = (c != CH_N);
			FLD_LON: begin
				if (cpos == 5) begin
					if (c != CH_DOT) bad = 1;
				end else begin
					want = 1;
					if (cpos == 0) lon_d = 8'(d);
					else if (cpos == 1) lon_d = 8'(32'(lon_d) * 10 + d);
					else if (cpos == 2) lon_d = 8'(pair(32'(lon_d), d, 0, 180));
					else if (cpos == 3) lon_m = 6'(d);
					else if (cpos == 4) lon_m = 6'(pair(32'(lon_m), d, 0, 59));
					else if (cpos >= 6 && cpos <= 10)
						lon_f = 17'(32'(lon_f) + d * pow10(32'(cpos) - 6));
				end
			end
			FLD_EW: if (cpos == 0) west = (c != CH_E);
			FLD_DATE: begin
				want = 1;
				case (cpos)
					0: dd = 5'(d);
					1: dd = 5'(pair(32'(dd), d, 1, 31));
					2: mo = 4'(d);
					3: mo = 4'(pair(32'(mo), d, 1, 12));
					4: yy = 7'(d);
					5: yy = 7'(pair(32'(yy), d, 0, 99));
					default: ;
				endcase
			end
			default: ;
		endcase
		if (want && !isd)
			bad = 1;
	endtask

	task automatic close_field();
		case (fld)
			FLD_HDR:  if (cpos != 5) hdr_ok = 0;
			FLD_TIME: if (cpos < 6) bad = 1;
			FLD_LAT:  if (cpos < 4 || lat_units() > 32'(LAT_MAX_UNITS)) bad = 1;
			FLD_LON:  if (cpos < 5 || lon_units() > 32'(LON_MAX_UNITS)) bad = 1;
			FLD_DATE: if (cpos != 6) bad = 1;
			default: ;
		endcase
	endtask

	function automatic longint unsigned epoch_days(longint unsigned y,
			longint unsigned m, longint unsigned d);
		longint unsigned ya, era, yoe, mp, doy, doe;
		ya = y - ((m <= 2) ? 1 : 0);
		era = ya / 400;
		yoe = ya - era * 400;
		mp = (m > 2) ? m - 3 : m + 9;
		doy = (153 * mp + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	task automatic predict_fix(input logic [7:0] c, input logic p, output fix_t r);
		logic [31:0] sod, lat, lon;
		longint unsigned utc;
		r = '0;
		if (c == CH_DOLLAR) begin
			clear_sentence();
			if (p) begin
				open_s = 1; hdr_ok = 1; south = 1; west = 1;
			end
		end else if (open_s) begin
			if (c == CH_COMMA || c == CH_STAR || c == CH_CR || c == CH_LF) begin
				close_field();
				if (c == CH_COMMA) begin
					if (fld != 4'd15) fld = fld + 4'd1;
					cpos = 0;
				end else begin
					if (hdr_ok && !bad && fld >= FLD_DATE) begin
						sod = 32'(hh) * 3600 + 32'(mm) * 60 + 32'(ss);
						lat = lat_units();
						lon = lon_units();
						if (south) lat = 32'd0 - lat;
						if (west) lon = 32'd0 - lon;
						utc = epoch_days(64'(2000) + 64'(yy), 64'(mo), 64'(dd)) * 86400
							+ 64'(sod);
						r.valid_res = 1;
						r.hour = hh;
						r.minute = mm;
						r.second = ss;
						r.day = dd;
						r.month = mo;
						r.year = 12'(32'd2000 + 32'(yy));
						r.sec_of_day = sod[16:0];
						r.latitude = lat[30:0];
						r.longitude = lon;
						r.utc_seconds = utc[31:0];
					end
					open_s = 0;
				end
			end else begin
				take_char(c);
				if (cpos != 4'd15) cpos = cpos + 4'd1;
			end
		end
	endtask

	assign pending = fix_q.size();

	initial begin
		errors = 0;
		clear_sentence();
	end

	always @(posedge clk) begin
		fix_t want_r, got_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got_r = {valid_res, hour, minute, second, day, month, year, sec_of_day,
					latitude, longitude, utc_seconds};
				if (fix_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result item with none expected", $realtime);
				end else begin
					want_r = fix_q.pop_front();
					if (got_r !== want_r) begin
						errors++;
						if (errors <= 10) begin
							$display(
								"%0t: mismatch exp v=%0d %0d:%0d:%0d %0d/%0d/%0d sod=%0d lat=%0d lon=%0d utc=%0d",
								$realtime, want_r.valid_res, want_r.hour, want_r.minute,
								want_r.second, want_r.day, want_r.month, want_r.year,
								want_r.sec_of_day, $signed(want_r.latitude),
								$signed(want_r.longitude), want_r.utc_seconds);
							$display(
								"%0t:          got v=%0d %0d:%0d:%0d %0d/%0d/%0d sod=%0d lat=%0d lon=%0d utc=%0d",
								$realtime, got_r.valid_res, got_r.hour, got_r.minute,
								got_r.second, got_r.day, got_r.month, got_r.year,
								got_r.sec_of_day, $signed(got_r.latitude),
								$signed(got_r.longitude), got_r.utc_seconds);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_fix(rx_char, pps, want_r);
				fix_q.push_back(want_r);
			end
		end
	end
endmodule

>>> tb/tb.sv
// Testbench top for the RMC parser: clock, reset, sentence stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps
module tb
	import nrmc_pkg::*;
();
	localparam int IDLE_LIMIT = 5000;

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready;
	logic [7:0]  rx_char;
	logic        pps;
	logic        valid_res;
	logic [4:0]  hour, day;
	logic [5:0]  minute, second;
	logic [3:0]  month;
	logic [11:0] year;
	logic [16:0] sec_of_day;
	logic signed [30:0] latitude;
	logic signed [31:0] longitude;
	logic [31:0] utc_seconds;
	int          errors, pending;
	int          idle_cycles, burst_left, stall_left, rx_mode, mode_cycles;
	int          chars_sent;
	byte unsigned line_q[$];

	nmea_rmc_time_position_parser DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.rx_char(rx_char), .pps(pps), .out_valid(out_valid), .out_ready(out_ready),
		.valid_res(valid_res), .hour(hour), .minute(minute), .second(second),
		.day(day), .month(month), .year(year), .sec_of_day(sec_of_day),
		.latitude(latitude), .longitude(longitude), .utc_seconds(utc_seconds)
	);

	nrmc_checker CHK (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.rx_char(rx_char), .pps(pps), .out_valid(out_valid), .out_ready(out_ready),
		.valid_res(valid_res), .hour(hour), .minute(minute), .second(second),
		.day(day), .month(month), .year(year), .sec_of_day(sec_of_day),
		.latitude(latitude), .longitude(longitude), .utc_seconds(utc_seconds),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	// receiver: stall pattern switches between none, light and heavy
	always @(negedge clk) begin
		if (mode_cycles == 0) begin
			rx_mode <= $urandom_range(0, 2);
			mode_cycles <= $urandom_range(100, 400);
		end else
			mode_cycles <= mode_cycles - 1;
		if (stall_left > 0) begin
			out_ready <= 0;
			stall_left <= stall_left - 1;
		end else if (rx_mode != 0 && $urandom_range(0, rx_mode == 1 ? 15 : 3) == 0) begin
			out_ready <= 0;
			stall_left <= $urandom_range(0, rx_mode == 1 ? 4 : 15);
		end else
			out_ready <= 1;
	end

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	task automatic add_num(input int unsigned v, input int n);
		int unsigned w;
		for (int i = n - 1; i >= 0; i--) begin
			w = 1;
			repeat (i) w = w * 10;
			line_q.push_back(8'(CH_0 + (v / w) % 10));
		end
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic drive_char(input logic [7:0] c, input logic p);
		if (burst_left == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 30)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
		end
		in_valid <= 1;
		rx_char <= c;
		pps <= p;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_line(input logic dollar_pps);
		foreach (line_q[i])
			drive_char(line_q[i], line_q[i] == CH_DOLLAR ? dollar_pps : 1'($urandom_range(0, 1)));
		line_q.delete();
	endtask

	task automatic send_str(input string s, input logic dollar_pps);
		add_str(s);
		send_line(dollar_pps);
	endtask

	task automatic build_sentence();
		bit wide;
		int nf;
		wide = ($urandom_range(0, 7) == 0);
		add_str($urandom_range(0, 1) ? "$GPRMC," : "$GNRMC,");
		add_num(wide ? $urandom_range(0, 99) : $urandom_range(0, 23), 2);
		add_num(wide ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
		add_num(wide ? $urandom_range(0, 99) : $urandom_range(0, 60), 2);
		if ($urandom_range(0, 1)) begin
			add_str(".");
			add_num($urandom_range(0, 99), $urandom_range(1, 2));
		end
		add_str($urandom_range(0, 1) ? ",A," : ",V,");
		add_num(wide ? $urandom_range(0, 99) : $urandom_range(0, 90), 2);
		add_num(wide ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
		nf = $urandom_range(0, 7);
		if (nf > 0 || $urandom_range(0, 1)) add_str(".");
		if (nf > 0) add_num($urandom(), nf);
		case ($urandom_range(0, 5))
			0: add_str(",,");
			1: add_str(",X,");
			2, 3: add_str(",N,");
			default: add_str(",S,");
		endcase
		add_num(wide ? $urandom_range(0, 999) : $urandom_range(0, 180), 3);
		add_num(wide ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
		nf = $urandom_range(0, 7);
		if (nf > 0 || $urandom_range(0, 1)) add_str(".");
		if (nf > 0) add_num($urandom(), nf);
		case ($urandom_range(0, 5))
			0: add_str(",,");
			1: add_str(",Q,");
			2, 3: add_str(",E,");
			default: add_str(",W,");
		endcase
		add_str("0.5,12.0,");
		add_num(wide ? $urandom_range(0, 99) : $urandom_range(1, 31), 2);
		add_num(wide ? $urandom_range(0, 15) : $urandom_range(1, 12), 2);
		add_num($urandom_range(0, 99), 2);
		case ($urandom_range(0, 3))
			0: add_str("\r\n");
			1: add_str("\n");
			default: add_str(",,,A*5C\r\n");
		endcase
	endtask

	task automatic mangle_line();
		int k;
		k = $urandom_range(1, line_q.size() - 1);
		case ($urandom_range(0, 3))
			0: line_q[k] = 8'($urandom_range(0, 255));
			1: line_q = line_q[0:k];
			2: line_q.insert(k, CH_DOLLAR);
			default: line_q.insert(k, CH_COMMA);
		endcase
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		rx_char = 0;
		pps = 0;
		out_ready = 0;
		idle_cycles = 0;
		burst_left = 0;
		stall_left = 0;
		rx_mode = 0;
		mode_cycles = 0;
		chars_sent = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_str("x,$$*\r\n", 1);
		send_str("$GPRMC,000000,A,0000.00000,N,00000.00000,E,,,010100,,*00\r\n", 1);
		send_str("$GNRMC,235960.99,A,9000.00000,S,18000.00000,W,0.0,0.0,311299,,,A*1F\r\n", 1);
		send_str("$GPRMC,123519,A,4807.038,N,01131.0,E,022.4,084.4,230394,003.1,W\r", 1);
		send_str("$GPRMC,081836,A,3751.65123456,,14507.36,,0.0,0.0,150298\n", 1);
		send_str("$GPRMC,123519,A,4807.038,N,01131.0,E,,,230394*", 0);
		send_str("$GPRMC,1235$GPRMC,123519,A,4807.0,N,01131.0,E,,,230394*", 1);
		send_str("$GPRMC,123519,A,4807.0,N,$GPRMC,0,A,4807.0,N,01131.0,E,,,230394*", 0);
		send_str("$GPRMX,123519,A,4807.0,N,01131.0,E,,,230394*", 1);
		send_str("$GPRMC,12a519,A,4807.0,N,01131.0,E,,,230394*", 1);
		send_str("$GPRMC,240000,A,4807.0,N,01131.0,E,,,230394*", 1);
		send_str("$GPRMC,123519,A,9000.00001,N,01131.0,E,,,230394*", 1);
		send_str("$GPRMC,123519,A,4860.0,N,18000.00001,E,,,230394*", 1);
		send_str("$GPRMC,123519,A,4807.0,N,01131.0,E,,,000394*", 1);
		send_str("$GPRMC,123519,A,4807.0,N,01131.0,E,,,2303941*", 1);
		send_str("$GPRMC,123519,A*", 1);
		send_str("$GPRMC,123519,A,4807.0,N,01131.0,E,,,230394,,,,,,,,,,,,,,,,,,*\r\n", 1);

		in_valid <= 0;
		while (pending != 0) @(negedge clk);

		while (chars_sent < 900) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8))
					line_q.push_back(8'($urandom_range(0, 255)));
				send_line(1'($urandom_range(0, 1)));
			end
			build_sentence();
			if ($urandom_range(0, 4) == 0)
				mangle_line();
			send_line($urandom_range(0, 9) != 0);
			if ($urandom_range(0, 19) == 0) begin
				in_valid <= 0;
				while (pending != 0) @(negedge clk);
			end
		end

		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
